/* src/dem_pkg.sv */
package dem_pkg;

   typedef enum logic [3:0] {
      MODE_NONE        = 4'd0,
      MODE_COVER_PEND  = 4'd1,
      MODE_COVER_WAIT  = 4'd2,
      MODE_NODISK_PEND = 4'd3,
      MODE_NODISK_WAIT = 4'd4,
      MODE_WRONG_PEND  = 4'd5,
      MODE_WRONG_WAIT  = 4'd6,
      MODE_RETRY_PEND  = 4'd7,
      MODE_RETRY_WAIT  = 4'd8,
      MODE_FATAL_PEND  = 4'd9,
      MODE_FATAL_WAIT  = 4'd10
   } mode_type;

   typedef logic signed [4:0] status_type;

   localparam status_type ST_FATAL  = -5'sd1;
   localparam status_type ST_NODISK = 5'sd4;
   localparam status_type ST_COVER  = 5'sd5;
   localparam status_type ST_WRONG  = 5'sd6;
   localparam status_type ST_RETRY  = 5'sd11;

   typedef logic [2:0] category_type;

   localparam category_type CAT_NONE   = 3'd0;
   localparam category_type CAT_COVER  = 3'd1;
   localparam category_type CAT_NODISK = 3'd2;
   localparam category_type CAT_WRONG  = 3'd3;
   localparam category_type CAT_RETRY  = 3'd4;
   localparam category_type CAT_FATAL  = 3'd5;

   typedef struct packed {
      logic         recovered_strobe;
      logic         message_valid;
      category_type message_code;
      category_type error_category;
   } result_type;

   function automatic category_type category_of(mode_type mode);
      category_type cat;
      case (mode)
         MODE_COVER_PEND, MODE_COVER_WAIT:   cat = CAT_COVER;
         MODE_NODISK_PEND, MODE_NODISK_WAIT: cat = CAT_NODISK;
         MODE_WRONG_PEND, MODE_WRONG_WAIT:   cat = CAT_WRONG;
         MODE_RETRY_PEND, MODE_RETRY_WAIT:   cat = CAT_RETRY;
         MODE_FATAL_PEND, MODE_FATAL_WAIT:   cat = CAT_FATAL;
         default:                            cat = CAT_NONE;
      endcase
      return cat;
   endfunction

endpackage

/* src/dem_step.sv */
module dem_step
   import dem_pkg::*;
(
   input  mode_type   mode,
   input  status_type drive_status,
   input  logic       disk_check_ok,
   input  logic       driver_ready,
   output mode_type   mode_next,
   output result_type result
);

   status_type   st;
   logic         strobe;
   logic         msg_valid;
   category_type msg_code;
   status_type   own;

   always_comb begin
      st        = driver_ready ? drive_status : ST_FATAL;
      strobe    = 1'b0;
      msg_valid = 1'b0;
      msg_code  = CAT_NONE;
      mode_next = mode;
      own       = ST_COVER;

      case (mode)
         MODE_NONE: begin
            if (st == ST_FATAL) begin
               mode_next = MODE_FATAL_PEND;
            end else if (st == ST_COVER) begin
               mode_next = MODE_COVER_PEND;
            end else if (st == ST_NODISK) begin
               mode_next = MODE_NODISK_PEND;
            end else if (st == ST_WRONG) begin
               mode_next = MODE_WRONG_PEND;
            end else if (st == ST_RETRY) begin
               mode_next = MODE_RETRY_PEND;
            end
         end
         MODE_COVER_PEND, MODE_NODISK_PEND, MODE_WRONG_PEND,
         MODE_RETRY_PEND, MODE_FATAL_PEND: begin
            // pending modes raise their message and move to the waiting mode
            msg_valid = 1'b1;
            msg_code  = category_of(mode);
            mode_next = mode_type'(mode + 4'd1);
         end
         MODE_COVER_WAIT, MODE_NODISK_WAIT, MODE_WRONG_WAIT: begin
            if (mode == MODE_COVER_WAIT) begin
               own = ST_COVER;
            end else if (mode == MODE_NODISK_WAIT) begin
               own = ST_NODISK;
            end else begin
               own = ST_WRONG;
            end
            if (st == ST_RETRY) begin
               strobe    = 1'b1;
               msg_valid = 1'b1;
               msg_code  = CAT_RETRY;
               mode_next = MODE_RETRY_WAIT;
            end else if (st != own && disk_check_ok) begin
               strobe    = 1'b1;
               mode_next = MODE_NONE;
            end
         end
         MODE_RETRY_WAIT: begin
            if (st == ST_COVER) begin
               strobe    = 1'b1;
               msg_valid = 1'b1;
               msg_code  = CAT_COVER;
               mode_next = MODE_COVER_WAIT;
            end else if (st == ST_NODISK) begin
               strobe    = 1'b1;
               msg_valid = 1'b1;
               msg_code  = CAT_NODISK;
               mode_next = MODE_NODISK_WAIT;
            end else if ((st != ST_RETRY && disk_check_ok) || st == ST_NODISK
                         || st == ST_COVER) begin
               // cover open and no disk are taken above, so the trailing terms never fire
               strobe    = 1'b1;
               mode_next = MODE_NONE;
            end
         end
         default: begin
            // fatal waiting and unused codes hold
            mode_next = mode;
         end
      endcase

      result.recovered_strobe = strobe;
      result.message_valid    = msg_valid;
      result.message_code     = msg_code;
      result.error_category   = category_of(mode_next);
   end

endmodule

/* src/drive_error_monitor_fsm_core.sv */
// Drive error monitor: one polling request per cycle, back to back, while the
// response side keeps up. A request is taken into an input register; once the
// result register is free the error mode advances and the response lands in
// that result register. Throughput is one request per cycle when responses are
// drained, set by the update loop around the error mode register. Both sides
// stall independently: a waiting response holds its register while one more
// request may sit in the input register. csr_wr_data, written when csr_wr_en is
// high, sets the registered driver-ready flag; while that flag is low every
// request is treated as a fatal drive status.
module drive_error_monitor_fsm_core
   import dem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [4:0] req_drive_status,
   input  logic        req_disk_check_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_recovered_strobe,
   output logic        rsp_message_valid,
   output logic [2:0]  rsp_message_code,
   output logic [2:0]  rsp_error_category,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic       ready_ff;
   logic       ready_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   status_type in_status_ff;
   logic       in_check_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;
   mode_type   mode_ff;
   mode_type   mode_in;
   mode_type   mode_next;
   result_type step_result;
   logic       advance;
   logic       req_take;

   dem_step u_step (
      .mode          (mode_ff),
      .drive_status  (in_status_ff),
      .disk_check_ok (in_check_ff),
      .driver_ready  (ready_ff),
      .mode_next     (mode_next),
      .result        (step_result)
   );

   // result register frees up when empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      ready_in     = csr_wr_en ? csr_wr_data : ready_ff;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
      mode_in      = advance ? mode_next : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_NONE;
      end else begin
         ready_ff     <= ready_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_status_ff <= req_drive_status;
         in_check_ff  <= req_disk_check_ok;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_recovered_strobe = out_result_ff.recovered_strobe;
   assign rsp_message_valid    = out_result_ff.message_valid;
   assign rsp_message_code     = out_result_ff.message_code;
   assign rsp_error_category   = out_result_ff.error_category;

endmodule

/* sim/drive_error_monitor_fsm_core_tb.sv */
`timescale 1ns / 100ps

module drive_error_monitor_fsm_core_tb;
   import dem_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int FORCED_FATAL_TICKS = 40;

   // tracks the drive error mode and holds the responses still owed by the block
   class tick_scoreboard;
      mode_type   mode;
      bit         driver_ready;
      result_type due_responses[$];
      int         errors;

      function new();
         mode = MODE_NONE;
         driver_ready = 1'b0;
         errors = 0;
      endfunction

      function category_type mode_category(mode_type m);
         if (m >= MODE_COVER_PEND && m <= MODE_FATAL_WAIT) begin
            return category_type'((m + 1) >> 1);
         end
         return CAT_NONE;
      endfunction

      function void note_request(status_type status, logic disk_ok);
         status_type st;
         status_type own;
         mode_type   next;
         result_type r;
         st = driver_ready ? status : ST_FATAL;
         next = mode;
         r = '0;
         case (mode)
            MODE_NONE: begin
               if (st == ST_FATAL) next = MODE_FATAL_PEND;
               else if (st == ST_COVER) next = MODE_COVER_PEND;
               else if (st == ST_NODISK) next = MODE_NODISK_PEND;
               else if (st == ST_WRONG) next = MODE_WRONG_PEND;
               else if (st == ST_RETRY) next = MODE_RETRY_PEND;
            end
            MODE_COVER_PEND, MODE_NODISK_PEND, MODE_WRONG_PEND, MODE_RETRY_PEND,
            MODE_FATAL_PEND: begin
               r.message_valid = 1'b1;
               r.message_code = mode_category(mode);
               next = mode_type'(mode + 4'd1);
            end
            MODE_COVER_WAIT, MODE_NODISK_WAIT, MODE_WRONG_WAIT: begin
               case (mode)
                  MODE_COVER_WAIT:  own = ST_COVER;
                  MODE_NODISK_WAIT: own = ST_NODISK;
                  default:          own = ST_WRONG;
               endcase
               if (st == ST_RETRY) begin
                  r.recovered_strobe = 1'b1;
                  r.message_valid = 1'b1;
                  r.message_code = CAT_RETRY;
                  next = MODE_RETRY_WAIT;
               end else if (st != own && disk_ok) begin
                  r.recovered_strobe = 1'b1;
                  next = MODE_NONE;
               end
            end
            MODE_RETRY_WAIT: begin
               if (st == ST_COVER) begin
                  r.recovered_strobe = 1'b1;
                  r.message_valid = 1'b1;
                  r.message_code = CAT_COVER;
                  next = MODE_COVER_WAIT;
               end else if (st == ST_NODISK) begin
                  r.recovered_strobe = 1'b1;
                  r.message_valid = 1'b1;
                  r.message_code = CAT_NODISK;
                  next = MODE_NODISK_WAIT;
               // cover open and no disk are taken above, so the trailing terms never fire
               end else if ((st != ST_RETRY && disk_ok) || st == ST_NODISK
                            || st == ST_COVER) begin
                  r.recovered_strobe = 1'b1;
                  next = MODE_NONE;
               end
            end
            default: ;
         endcase
         mode = next;
         r.error_category = mode_category(next);
         due_responses.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (due_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = due_responses.pop_front();
         if (got.recovered_strobe !== want.recovered_strobe)
            report_mismatch($sformatf("recovered_strobe %b, want %b",
                                      got.recovered_strobe, want.recovered_strobe));
         if (got.message_valid !== want.message_valid)
            report_mismatch($sformatf("message_valid %b, want %b",
                                      got.message_valid, want.message_valid));
         if (got.message_code !== want.message_code)
            report_mismatch($sformatf("message_code %0d, want %0d",
                                      got.message_code, want.message_code));
         if (got.error_category !== want.error_category)
            report_mismatch($sformatf("error_category %0d, want %0d",
                                      got.error_category, want.error_category));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   status_type req_drive_status;
   logic       req_disk_check_ok;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_recovered_strobe;
   logic       rsp_message_valid;
   logic [2:0] rsp_message_code;
   logic [2:0] rsp_error_category;
   logic       csr_wr_en;
   logic       csr_wr_data;

   tick_scoreboard sb;
   result_type     got_rsp;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             stall_cycles;

   // directed walk through every mode but the fatal ones, starting from no error with the driver ready
   status_type dir_status [25] = '{
      5'sd0, 5'sd15, ST_COVER, ST_COVER, ST_COVER, 5'sd0, 5'sd0,
      ST_NODISK, 5'sd0, ST_FATAL, ST_RETRY, ST_RETRY, ST_COVER, ST_NODISK,
      ST_RETRY, ST_NODISK, ST_RETRY, 5'sd0,
      ST_WRONG, ST_WRONG, ST_WRONG, 5'sd7,
      ST_RETRY, 5'sd3, ST_FATAL};
   bit dir_check [25] = '{
      0, 1, 0, 1, 1, 0, 1,
      0, 0, 0, 0, 1, 0, 0,
      1, 1, 0, 1,
      1, 0, 1, 1,
      0, 1, 1};

   drive_error_monitor_fsm_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_drive_status     (req_drive_status),
      .req_disk_check_ok    (req_disk_check_ok),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_recovered_strobe (rsp_recovered_strobe),
      .rsp_message_valid    (rsp_message_valid),
      .rsp_message_code     (rsp_message_code),
      .rsp_error_category   (rsp_error_category),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rsp = {rsp_recovered_strobe, rsp_message_valid, rsp_message_code,
                    rsp_error_category};
         sb.check_result(got_rsp);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // fatal is a sink, so -1 is only offered where it cannot start a fatal error
   function status_type pick_status(bit allow_fatal);
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return ST_COVER;
      if (r < 30) return ST_NODISK;
      if (r < 45) return ST_WRONG;
      if (r < 60) return ST_RETRY;
      if (r < 66 && allow_fatal) return ST_FATAL;
      return status_type'($urandom_range(0, 15));
   endfunction

   task send_request(status_type status, logic disk_ok);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_drive_status = status;
      req_disk_check_ok = disk_ok;
      do @(posedge clock); while (!req_ready);
      sb.note_request(status, disk_ok);
   endtask

   task drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.due_responses.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_driver_ready(logic value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.driver_ready = value;
   endtask

   task random_ticks(int count);
      repeat (count) send_request(pick_status(sb.mode != MODE_NONE), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      sb = new();
      stall_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_drive_status = '0;
      req_disk_check_ok = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 46;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      write_driver_ready(1'b1);
      foreach (dir_status[i]) send_request(dir_status[i], dir_check[i]);
      random_ticks(RANDOM_PER_PHASE);

      // park in a waiting mode, then run a few requests with the driver not ready
      while (sb.mode != MODE_COVER_WAIT && sb.mode != MODE_NODISK_WAIT &&
             sb.mode != MODE_WRONG_WAIT && sb.mode != MODE_RETRY_WAIT) begin
         send_request((sb.mode == MODE_NONE) ? ST_COVER : 5'sd0, 1'b0);
      end
      drain();
      write_driver_ready(1'b0);
      repeat (6) send_request(pick_status(1'b1), 1'b0);
      drain();
      write_driver_ready(1'b1);

      send_idle_pct = 46;
      recv_idle_pct = 11;
      random_ticks(RANDOM_PER_PHASE);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_ticks(RANDOM_PER_PHASE);
      drain();

      // driver not ready: every request reads as fatal; once in the fatal modes the block never recovers
      write_driver_ready(1'b0);
      repeat (FORCED_FATAL_TICKS) send_request(pick_status(1'b1), 1'($urandom_range(0, 1)));
      drain();
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.due_responses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
